// ===== src/stream_deduplicator_top_macros.svh =====
// Assertion macros shared by the deduplicator RTL.
`ifndef STREAM_DEDUPLICATOR_TOP_MACROS_SVH
`define STREAM_DEDUPLICATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deduplicator check failed");

// Next-cycle implication, checked outside reset.
`define SDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deduplicator check failed");

`endif

// ===== src/sdd_pkg.sv =====
// Shared types and constants for the stream deduplicator.
package sdd_pkg;

    localparam int DefTableDepth = 256;
    localparam int DefValueWidth = 32;
    localparam int DataW         = 32;
    localparam int CountOutW     = 9;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             first_item;
        logic             last_item;
    } t_in_item;

    typedef struct packed {
        logic [DataW-1:0]     value_out;
        logic                 is_new;
        logic [CountOutW-1:0] unique_count;
        logic                 table_full;
        logic                 run_end;
    } t_out_item;

endpackage

// ===== src/sdd_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
module sdd_ram #(
    parameter int Depth = 256,
    parameter int Width = 32,
    parameter int AddrW = 8
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [Width-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [Width-1:0] i_wr_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sdd_scan.sv =====
// Scan controller: walks the stored entries, appends new values, builds the result.
module sdd_scan
    import sdd_pkg::*;
#(
    parameter int TableDepth = DefTableDepth,
    parameter int StoreW     = DefValueWidth,
    parameter int AddrW      = 8,
    parameter int CntW       = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_res_valid,
    output t_out_item         o_res_item,
    input  logic              i_res_take,
    output logic              o_rd_en,
    output logic [AddrW-1:0]  o_rd_addr,
    input  logic [StoreW-1:0] i_rd_data,
    output logic              o_wr_en,
    output logic [AddrW-1:0]  o_wr_addr,
    output logic [StoreW-1:0] o_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [CntW-1:0] DepthC = CntW'(TableDepth);

    t_state            r_state,   n_state;
    logic [CntW-1:0]   r_count,   n_count;
    logic [CntW-1:0]   r_idx,     n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [StoreW-1:0] r_value,   n_value;
    logic              r_last,    n_last;
    t_out_item         r_res,     n_res;

    logic              hit;
    logic              is_new;
    logic              full;
    logic [CntW-1:0]   cnt_after;
    logic [31:0]       cnt_ext;

    // Compare the entry read last cycle
    assign hit = r_cmp_vld && (i_rd_data == r_value);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_value   = r_value;
        n_last    = r_last;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_wr_en   = 1'b0;
        is_new    = !hit;
        full      = 1'b0;
        cnt_after = r_count;
        cnt_ext   = '0;

        case (r_state)
            S_IDLE: begin
                // Latch the transaction; first element restarts the table
                if (i_in_valid) begin
                    n_value = i_in_item.value[StoreW-1:0];
                    n_last  = i_in_item.last_item;
                    n_idx   = '0;
                    if (i_in_item.first_item) begin
                        n_count = '0;
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || (r_idx == r_count)) begin
                    // Finish: append a new value while there is room
                    full = is_new && (r_count == DepthC);
                    if (is_new && !full) begin
                        o_wr_en   = 1'b1;
                        cnt_after = r_count + CntW'(1);
                    end
                    n_count            = cnt_after;
                    cnt_ext            = 32'(cnt_after);
                    n_res.value_out    = DataW'(r_value);
                    n_res.is_new       = is_new;
                    n_res.unique_count = cnt_ext[CountOutW-1:0];
                    n_res.table_full   = full;
                    n_res.run_end      = r_last;
                    n_state            = S_DONE;
                end else begin
                    // Advance to the next stored entry
                    o_rd_en   = 1'b1;
                    n_idx     = r_idx + CntW'(1);
                    n_cmp_vld = 1'b1;
                end
            end
            S_DONE: begin
                // Hold the result until the output stage takes it
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
        r_idx   <= n_idx;
        r_value <= n_value;
        r_last  <= n_last;
        r_res   <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res_item  = r_res;
    assign o_rd_addr   = r_idx[AddrW-1:0];
    assign o_wr_addr   = r_count[AddrW-1:0];
    assign o_wr_data   = r_value;

endmodule

// ===== src/stream_deduplicator_top.sv =====
// Top level of the streaming duplicate remover: table memory, scan control, output stage.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  input   | in        | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  output  | out       | o_out_valid / i_out_stall| o_out_item (t_out_item)
//
// For each item the scan walks the N entries stored before it (at most
// TABLE_DEPTH), reading one table entry per cycle through the single
// memory read port, and stops early on a match.
// Reset is synchronous and active low; it clears the entry count, so the
// table reads as empty, and no clearing pass is needed.
// A finished result waits in the output register while the next item is
// taken; the scan holds its result only when that register stays stalled.
`include "stream_deduplicator_top_macros.svh"

module stream_deduplicator_top
    import sdd_pkg::*;
#(
    parameter int TABLE_DEPTH = DefTableDepth,
    parameter int VALUE_WIDTH = DefValueWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int StoreW = (VALUE_WIDTH < DataW) ? VALUE_WIDTH : DataW;
    localparam int AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW   = $clog2(TABLE_DEPTH + 1);

    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
    logic [StoreW-1:0] rd_data;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic [StoreW-1:0] wr_data;
    logic              res_valid;
    t_out_item         res_item;
    logic              res_take;
    logic              r_out_valid;
    t_out_item         r_out_item;

    sdd_ram #(
        .Depth (TABLE_DEPTH),
        .Width (StoreW),
        .AddrW (AddrW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    sdd_scan #(
        .TableDepth (TABLE_DEPTH),
        .StoreW     (StoreW),
        .AddrW      (AddrW),
        .CntW       (CntW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .o_res_item  (res_item),
        .i_res_take  (res_take),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Move the result into the output register when it is free or draining
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A full table flag only ever comes with a new value
    `SDD_ASSERT_NOW(a_full_is_new, i_clk, i_rst_n, res_valid && res_item.table_full, res_item.is_new)
    // No transaction is taken while a result is pending in the scan
    `SDD_ASSERT_NOW(a_busy_with_result, i_clk, i_rst_n, res_valid, o_in_stall)
    // An accepted transaction keeps the input side busy next cycle
    `SDD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

// ===== sim/stream_deduplicator_top_test.sv =====
// Self-checking testbench for the streaming duplicate remover.
module stream_deduplicator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sdd_pkg::*;

    localparam int IdlePct    = 24;
    localparam int RandomGoal = 1700;
    localparam int DrainWait  = 300;
    localparam int HoldLen    = 600;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Shaping of both sides of the handshake
    int unsigned send_idle_pct = IdlePct;
    int unsigned recv_stall_pct = IdlePct;
    // Hold-off requests come from the tests; the receiver counts the cycles itself
    int unsigned hold_req_cnt = 0;
    int unsigned hold_ack_cnt = 0;
    int unsigned hold_cycles = 0;

    // Private copy of the seen-value table
    logic [DataW-1:0] seen_tbl [DefTableDepth];
    int unsigned      seen_cnt = 0;
    t_out_item        dedup_results_q[$];

    int unsigned err_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned array_cnt = 0;
    int unsigned dup_cnt = 0;
    int unsigned full_cnt = 0;

    stream_deduplicator_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Compute the result of one element and update the table
    function automatic t_out_item predict_dedup(t_in_item it);
        t_out_item r;
        bit        hit;
        if (it.first_item) begin
            seen_cnt = 0;
        end
        hit = 1'b0;
        for (int i = 0; i < seen_cnt; i++) begin
            if (seen_tbl[i] == it.value) begin
                hit = 1'b1;
            end
        end
        r.value_out  = it.value;
        r.is_new     = !hit;
        r.table_full = 1'b0;
        if (!hit) begin
            if (seen_cnt < DefTableDepth) begin
                seen_tbl[seen_cnt] = it.value;
                seen_cnt++;
            end else begin
                r.table_full = 1'b1;
            end
        end
        r.unique_count = CountOutW'(seen_cnt);
        r.run_end      = it.last_item;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s differs, expected %h, got %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send_transaction(logic [DataW-1:0] value, bit first, bit last);
        t_in_item  it;
        t_out_item r;
        it.value      = value;
        it.first_item = first;
        it.last_item  = last;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        r = predict_dedup(it);
        dedup_results_q.push_back(r);
        sent_cnt++;
        if (first) begin
            array_cnt++;
        end
        if (!r.is_new) begin
            dup_cnt++;
        end
        if (r.table_full) begin
            full_cnt++;
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_cycles  <= HoldLen;
            out_stall    <= 1'b1;
        end else if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (dedup_results_q.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, out_item);
                err_cnt++;
            end else begin
                want = dedup_results_q.pop_front();
                check_field("value_out", want.value_out, out_item.value_out);
                check_field("is_new", 32'(want.is_new), 32'(out_item.is_new));
                check_field("unique_count", 32'(want.unique_count),
                            32'(out_item.unique_count));
                check_field("table_full", 32'(want.table_full), 32'(out_item.table_full));
                check_field("run_end", 32'(want.run_end), 32'(out_item.run_end));
            end
        end
    end

    // Table starts empty after reset; elements without a first flag build on it
    task automatic test_after_reset();
        send_transaction(32'd5, 1'b0, 1'b0);
        send_transaction(32'd5, 1'b0, 1'b0);
        send_transaction(32'd0, 1'b0, 1'b1);
        // no first flag after the last one: table is kept
        send_transaction(32'd5, 1'b0, 1'b0);
        send_transaction(32'd9, 1'b0, 1'b1);
    endtask

    task automatic test_single_element_array();
        send_transaction(32'd5, 1'b1, 1'b1);
        send_transaction(32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    // Extreme values and duplicates of them
    task automatic test_extremes();
        send_transaction(32'h0000_0000, 1'b1, 1'b0);
        send_transaction(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_transaction(32'h8000_0000, 1'b0, 1'b0);
        send_transaction(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_transaction(32'h0000_0000, 1'b0, 1'b0);
        send_transaction(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_transaction(32'h0000_0001, 1'b0, 1'b0);
        send_transaction(32'h5555_AAAA, 1'b0, 1'b0);
        send_transaction(32'hAAAA_5555, 1'b0, 1'b0);
        send_transaction(32'h8000_0000, 1'b0, 1'b1);
    endtask

    // Fill all entries, then offer new values and a known one
    task automatic test_table_full();
        logic [DataW-1:0] base;
        base = $urandom;
        for (int i = 0; i < DefTableDepth; i++) begin
            send_transaction(base ^ DataW'(i), i == 0, 1'b0);
        end
        send_transaction(base ^ 32'h100, 1'b0, 1'b0);
        send_transaction(base ^ 32'h100, 1'b0, 1'b0);
        send_transaction(base ^ 32'h5, 1'b0, 1'b0);
        send_transaction(base ^ 32'h200, 1'b0, 1'b1);
    endtask

    // Hold the output off while the sender keeps offering
    task automatic test_backpressure();
        hold_req_cnt++;
        for (int i = 0; i < 30; i++) begin
            send_transaction(DataW'($urandom_range(7)), i == 0, i == 29);
        end
    endtask

    // Random arrays, mostly well formed, with some broken framing
    task automatic test_random_arrays();
        logic [DataW-1:0] pool[$];
        int unsigned      len;
        int unsigned      noise;
        int unsigned      mid_first;
        bit               first;
        bit               last;
        while (sent_cnt < RandomGoal) begin
            // a stretch with no idling on either side
            if (sent_cnt >= 700 && sent_cnt < 900) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                send_idle_pct  = IdlePct;
                recv_stall_pct = IdlePct;
            end
            len = ($urandom_range(99) < 3) ? $urandom_range(100, 300) : $urandom_range(1, 24);
            pool.delete();
            repeat ($urandom_range(1, len)) begin
                pool.push_back(($urandom_range(3) == 0) ? DataW'($urandom_range(7)) : $urandom);
            end
            noise     = $urandom_range(99);
            mid_first = (noise >= 14 && noise < 18) ? $urandom_range(len - 1) : len;
            for (int i = 0; i < len; i++) begin
                first = (i == 0 && !(noise < 8 && seen_cnt < 150)) || (i == mid_first);
                last  = (i == len - 1) && !(noise >= 8 && noise < 14);
                send_transaction(pool[$urandom_range(pool.size() - 1)], first, last);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_single_element_array();
        test_extremes();
        test_table_full();
        test_backpressure();
        test_random_arrays();
        @(negedge clk);
        in_valid <= 1'b0;
        // drain outstanding results, then allow for a late stray one
        while (dedup_results_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DrainWait) @(posedge clk);
        $display("Run covered %0d elements in %0d framed arrays: %0d repeats, %0d overflows.",
                 sent_cnt, array_cnt, dup_cnt, full_cnt);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", dedup_results_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sdd_pkg.sv
src/sdd_ram.sv
src/sdd_scan.sv
src/stream_deduplicator_top.sv
sim/stream_deduplicator_top_test.sv
